// ===== hw/rtl/fwrbv_pkg.sv =====
// Shared constants and types for the queue with remove-by-value.
`default_nettype none

package fwrbv_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  localparam logic signed [DATA_W-1:0] HEAD_NONE = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_with_remove_by_value_core.sv =====
// Bounded queue of signed words with push, pop, peek, remove-first-match and clear.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------------------
//   in      | in_valid, in_ready, mode, value           | one request per transaction
//   out     | out_valid, out_ready, head_value,         | one result per request
//           | entry_count, status                       |
//
// Push, clear, unknown modes and requests on an empty queue: result in the cycle after accept.
// Peek: reads the head entry. Pop: reads the head, then moves each later entry one place forward.
// Remove: compares entries from the head in turn, ending not-found on a miss; on a match, moves
// each entry behind it one place forward. All entry reads use the memory's registered read port.
// Reset empties the count; entries stay undefined until written, with no clearing pass.
// A new request is taken when idle and the result slot is free or being emptied in the same cycle.
`default_nettype none

module fifo_with_remove_by_value_core
  import fwrbv_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire        [MODE_W-1:0]  mode,
  input  wire signed [DATA_W-1:0]  value,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [DATA_W-1:0] head_value,
  output logic       [COUNT_W-1:0] entry_count,
  output logic       [STAT_W-1:0]  status
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  idx_inc;
  logic [MODE_W-1:0] op, op_next;
  logic [DATA_W-1:0] key, key_next;

  logic                     out_valid_next;
  logic signed [DATA_W-1:0] head_next;
  logic [STAT_W-1:0]        status_next;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic in_fire;
  logic out_fire;
  logic done;
  logic full;
  logic empty;

  assign in_ready    = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;
  assign idx_inc     = idx + CNT_W'(1);
  assign full        = (count >= CNT_W'(DEPTH));
  assign empty       = (count == '0);
  assign entry_count = COUNT_W'(count);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && !empty &&
            (mode == MODE_POP || mode == MODE_PEEK || mode == MODE_REMOVE)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (op == MODE_REMOVE) begin
          if (rd_data == key) begin
            state_next = ST_SHIFT_RD;
          end else if (idx_inc == count) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end else if (op == MODE_POP) begin
          state_next = ST_SHIFT_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_inc < count) begin
          state_next = ST_SHIFT_WR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next  = count;
    idx_next    = idx;
    op_next     = op;
    key_next    = key;
    head_next   = head_value;
    status_next = status;
    mem_we      = 1'b0;
    mem_waddr   = idx[IDX_W-1:0];
    mem_wdata   = rd_data;
    rd_addr     = idx[IDX_W-1:0];
    done        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          op_next     = mode;
          key_next    = value;
          idx_next    = '0;
          head_next   = '0;
          status_next = STAT_OK;
          unique case (mode)
            MODE_PUSH: begin
              done = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[IDX_W-1:0];
                mem_wdata  = value;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (empty) begin
                done        = 1'b1;
                head_next   = HEAD_NONE;
                status_next = STAT_EMPTY;
              end
            end
            MODE_REMOVE: begin
              if (empty) begin
                done        = 1'b1;
                status_next = STAT_EMPTY;
              end
            end
            MODE_CLEAR: begin
              done       = 1'b1;
              count_next = '0;
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_READ: rd_addr = idx[IDX_W-1:0];
      ST_CHECK: begin
        if (op == MODE_REMOVE) begin
          if (rd_data != key) begin
            idx_next = idx_inc;
            if (idx_inc == count) begin
              done        = 1'b1;
              status_next = STAT_NOTFOUND;
            end
          end
        end else begin
          head_next = rd_data;
          if (op == MODE_PEEK) begin
            done = 1'b1;
          end
        end
      end
      ST_SHIFT_RD: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (!(idx_inc < count)) begin
          done       = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[IDX_W-1:0];
        mem_wdata = rd_data;
        idx_next  = idx_inc;
      end
      default: ;
    endcase
    out_valid_next = done || (out_valid && !out_fire);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      op        <= MODE_PUSH;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    head_value <= head_next;
    status     <= status_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == MODE_PUSH && !full |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow the queue");

  a_busy_slot_free: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !out_valid)
    else $error("result pending while a request is in progress");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT_WR |-> idx_inc < count)
    else $error("shift beyond occupancy");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == STAT_EMPTY |-> count == '0)
    else $error("empty status with entries held");
`endif

endmodule

`default_nettype wire
